### src/lfpl_pkg.sv
// shared types and constants of the led frame power limiter
`default_nettype none

package lfpl_pkg;

    localparam int PIXELS_PER_BUS_DEF = 64;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ON      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_BUDGET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CURRENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_CURRENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_CURRENT = 3'd4;

    localparam logic        LIMIT_ON_RST      = 1'b1;
    localparam logic [15:0] POWER_BUDGET_RST  = 16'd2000;
    localparam logic [15:0] IDLE_CURRENT_RST  = 16'd50;
    localparam logic [7:0]  COLOR_CURRENT_RST = 8'd20;
    localparam logic [7:0]  WHITE_CURRENT_RST = 8'd20;

    // scale handling
    localparam logic [7:0] SCALE_FULL   = 8'd255;
    localparam logic [7:0] RELEASE_STEP = 8'd8;

    // ceil(sum / 255) saturates above this sum
    localparam logic [23:0] SUM_SAT   = 24'd16711425;
    // ceil(2^32 / 255), exact floor division for 24-bit dividends
    localparam logic [24:0] RECIP_255 = 25'd16843010;

    typedef struct packed {
        logic       start;
        logic [7:0] scale;
    } est_req_t;

    typedef struct packed {
        logic [7:0]  bright;
        logic [7:0]  color_current;
        logic [7:0]  white_current;
        logic [15:0] idle_current;
    } est_cfg_t;

    typedef struct packed {
        logic        done;
        logic [15:0] total;
    } est_rsp_t;

endpackage

`default_nettype wire

### src/led_frame_power_limiter_core.sv
// top level of the led frame power limiter: pixel intake, scale search, result register
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ---------------------------------------------
//  in       input      in_valid / in_ready    red green blue white bus_select pixel_slot
//                                             end_of_frame frame_brightness two_buses
//  out      output     out_valid / out_ready  out_scale demand_current drawn_current
//                                             peak_demand limited_frame_count
//  cfg      input      cfg_we                 cfg_index cfg_data
//
// a frame end runs one estimator pass per scale tried, each pass reading N stored pixels
// with N = PIXELS_PER_BUS or 2*PIXELS_PER_BUS (two_buses):
// one pass at full scale, eight search passes when over budget, one pass at the applied scale
// the estimator reads one stored pixel per cycle from the single read port of the store
// after reset the store is swept to zero, in_ready low until the sweep is done
// a result waits in the output register; the next frame end stalls only if it is still held
`default_nettype none

module led_frame_power_limiter_core #(
    parameter int PIXELS_PER_BUS = lfpl_pkg::PIXELS_PER_BUS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     red,
    input  logic [7:0]                     green,
    input  logic [7:0]                     blue,
    input  logic [7:0]                     white,
    input  logic                           bus_select,
    input  logic [5:0]                     pixel_slot,
    input  logic                           end_of_frame,
    input  logic [7:0]                     frame_brightness,
    input  logic                           two_buses,
    // frame result
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_scale,
    output logic [15:0]                    demand_current,
    output logic [15:0]                    drawn_current,
    output logic [15:0]                    peak_demand,
    output logic [31:0]                    limited_frame_count,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [lfpl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfpl_pkg::CFG_W-1:0]     cfg_data
);

    import lfpl_pkg::*;

    localparam int DEPTH  = 2 * PIXELS_PER_BUS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DEMAND = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_APPLY  = 3'd4;
    localparam logic [2:0] S_DRAWN  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]  state_reg, state_next;

    // configuration registers
    logic        limit_on_reg, limit_on_next;
    logic [15:0] budget_reg, budget_next;
    logic [15:0] idle_reg, idle_next;
    logic [7:0]  color_reg, color_next;
    logic [7:0]  white_reg, white_next;

    // frame state
    logic [7:0]  scale_reg, scale_next;
    logic [15:0] peak_reg, peak_next;
    logic [31:0] limited_reg, limited_next;
    logic [7:0]  bright_reg, bright_next;
    logic        two_reg, two_next;
    logic [15:0] demand_reg, demand_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  mid_reg, mid_next;
    logic [7:0]  safe_reg, safe_next;

    // estimator request
    logic        est_start_reg, est_start_next;
    logic [7:0]  est_scale_reg, est_scale_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_scale_reg, out_scale_next;
    logic [15:0] out_demand_reg, out_demand_next;
    logic [15:0] out_drawn_reg, out_drawn_next;
    logic [15:0] out_peak_reg, out_peak_next;
    logic [31:0] out_count_reg, out_count_next;

    logic              accept;
    logic              slot_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       rd_data;
    logic              clr_busy;
    logic [CNT_W-1:0]  pass_count;
    est_req_t          est_req;
    est_cfg_t          est_cfg;
    est_rsp_t          est_rsp;

    logic              cfg_hit;
    logic [7:0]        new_scale;
    logic [8:0]        up_sum;
    logic [7:0]        lo_upd, hi_upd;
    logic [8:0]        mid_sum;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // slots past the end of a bus are dropped, the frame end still counts
    assign slot_ok = 32'(pixel_slot) < 32'(PIXELS_PER_BUS);
    assign wr_addr = bus_select ? ADDR_W'(32'(PIXELS_PER_BUS) + 32'(pixel_slot))
                                : ADDR_W'(pixel_slot);

    assign pass_count = two_reg ? CNT_W'(DEPTH) : CNT_W'(PIXELS_PER_BUS);

    lfpl_store #(
        .DEPTH    (DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && slot_ok),
        .wr_addr  (wr_addr),
        .wr_data  ({white, blue, green, red}),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    assign est_req.start         = est_start_reg;
    assign est_req.scale         = est_scale_reg;
    assign est_cfg.bright        = bright_reg;
    assign est_cfg.color_current = color_reg;
    assign est_cfg.white_current = white_reg;
    assign est_cfg.idle_current  = idle_reg;

    lfpl_est_unit #(
        .PIXELS_PER_BUS (PIXELS_PER_BUS)
    ) u_est (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (est_req),
        .cfg     (est_cfg),
        .count   (pass_count),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (est_rsp)
    );

    // scale for this frame: full with the limiter off, else drop at once, recover by a fixed step
    always_comb
    begin
        up_sum = 9'(scale_reg) + 9'(RELEASE_STEP);
        priority if (!limit_on_reg)
        begin
            new_scale = SCALE_FULL;
        end
        else if (safe_reg < scale_reg)
        begin
            new_scale = safe_reg;
        end
        else if (safe_reg > scale_reg)
        begin
            new_scale = (up_sum < 9'(safe_reg)) ? up_sum[7:0] : safe_reg;
        end
        else
        begin
            new_scale = scale_reg;
        end
    end

    // binary search bounds after one trial pass
    always_comb
    begin
        lo_upd = lo_reg;
        hi_upd = hi_reg;
        if (est_rsp.total <= budget_reg)
        begin
            lo_upd = mid_reg;
        end
        else
        begin
            hi_upd = mid_reg - 1'b1;
        end
        mid_sum = (9'(lo_upd) + 9'(hi_upd) + 9'd1) >> 1;
    end

    always_comb
    begin
        state_next      = state_reg;
        limit_on_next   = limit_on_reg;
        budget_next     = budget_reg;
        idle_next       = idle_reg;
        color_next      = color_reg;
        white_next      = white_reg;
        scale_next      = scale_reg;
        peak_next       = peak_reg;
        limited_next    = limited_reg;
        bright_next     = bright_reg;
        two_next        = two_reg;
        demand_next     = demand_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        safe_next       = safe_reg;
        est_start_next  = 1'b0;
        est_scale_next  = est_scale_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_scale_next  = out_scale_reg;
        out_demand_next = out_demand_reg;
        out_drawn_next  = out_drawn_reg;
        out_peak_next   = out_peak_reg;
        out_count_next  = out_count_reg;
        cfg_hit         = 1'b0;

        // register writes; a cleared enable pins the scale at full
        if (cfg_we)
        begin
            cfg_hit = 1'b1;
            unique case (cfg_index)
                CFG_LIMIT_ON:      limit_on_next = cfg_data[0];
                CFG_POWER_BUDGET:  budget_next   = cfg_data[15:0];
                CFG_IDLE_CURRENT:  idle_next     = cfg_data[15:0];
                CFG_COLOR_CURRENT: color_next    = cfg_data[7:0];
                CFG_WHITE_CURRENT: white_next    = cfg_data[7:0];
                default:           cfg_hit       = 1'b0;
            endcase
        end
        if (cfg_hit && !limit_on_next)
        begin
            scale_next = SCALE_FULL;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                if (!clr_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // pixel is written by the store at this transfer
                if (accept && end_of_frame)
                begin
                    bright_next    = frame_brightness;
                    two_next       = two_buses;
                    est_start_next = 1'b1;
                    est_scale_next = SCALE_FULL;
                    state_next     = S_DEMAND;
                end
            end
            S_DEMAND:
            begin
                if (est_rsp.done)
                begin
                    demand_next = est_rsp.total;
                    if (est_rsp.total > peak_reg)
                    begin
                        peak_next = est_rsp.total;
                    end
                    if (limit_on_reg && est_rsp.total > budget_reg)
                    begin
                        lo_next        = 8'd0;
                        hi_next        = SCALE_FULL;
                        mid_next       = 8'd128;
                        est_start_next = 1'b1;
                        est_scale_next = 8'd128;
                        state_next     = S_SEARCH;
                    end
                    else
                    begin
                        safe_next  = SCALE_FULL;
                        state_next = S_APPLY;
                    end
                end
            end
            S_SEARCH:
            begin
                if (est_rsp.done)
                begin
                    lo_next = lo_upd;
                    hi_next = hi_upd;
                    if (lo_upd < hi_upd)
                    begin
                        mid_next       = mid_sum[7:0];
                        est_start_next = 1'b1;
                        est_scale_next = mid_sum[7:0];
                    end
                    else
                    begin
                        safe_next  = lo_upd;
                        state_next = S_APPLY;
                    end
                end
            end
            S_APPLY:
            begin
                scale_next = new_scale;
                if (limit_on_reg && new_scale != SCALE_FULL && limited_reg != 32'hFFFF_FFFF)
                begin
                    limited_next = limited_reg + 32'd1;
                end
                est_start_next = 1'b1;
                est_scale_next = new_scale;
                state_next     = S_DRAWN;
            end
            S_DRAWN:
            begin
                if (est_rsp.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // estimator holds the drawn total until its next pass
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_scale_next  = scale_reg;
                    out_demand_next = demand_reg;
                    out_drawn_next  = est_rsp.total;
                    out_peak_next   = peak_reg;
                    out_count_next  = limited_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            limit_on_reg  <= LIMIT_ON_RST;
            budget_reg    <= POWER_BUDGET_RST;
            idle_reg      <= IDLE_CURRENT_RST;
            color_reg     <= COLOR_CURRENT_RST;
            white_reg     <= WHITE_CURRENT_RST;
            scale_reg     <= SCALE_FULL;
            peak_reg      <= '0;
            limited_reg   <= '0;
            est_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_on_reg  <= limit_on_next;
            budget_reg    <= budget_next;
            idle_reg      <= idle_next;
            color_reg     <= color_next;
            white_reg     <= white_next;
            scale_reg     <= scale_next;
            peak_reg      <= peak_next;
            limited_reg   <= limited_next;
            est_start_reg <= est_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bright_reg     <= bright_next;
        two_reg        <= two_next;
        demand_reg     <= demand_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        safe_reg       <= safe_next;
        est_scale_reg  <= est_scale_next;
        out_scale_reg  <= out_scale_next;
        out_demand_reg <= out_demand_next;
        out_drawn_reg  <= out_drawn_next;
        out_peak_reg   <= out_peak_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid           = out_valid_reg;
    assign out_scale           = out_scale_reg;
    assign demand_current      = out_demand_reg;
    assign drawn_current       = out_drawn_reg;
    assign peak_demand         = out_peak_reg;
    assign limited_frame_count = out_count_reg;

endmodule

`default_nettype wire

### src/lfpl_store.sv
// pixel store: one write port, one registered read port, clearing sweep after reset
`default_nettype none

module lfpl_store #(
    parameter int  DEPTH  = 2 * lfpl_pkg::PIXELS_PER_BUS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data,
    output logic              clr_busy
);

    logic [31:0]       mem [DEPTH];
    logic [31:0]       rd_data_reg;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

### src/lfpl_est_unit.sv
// current estimator: one pass over the store per scale, pipelined one pixel a cycle
`default_nettype none

module lfpl_est_unit #(
    parameter int  PIXELS_PER_BUS = lfpl_pkg::PIXELS_PER_BUS_DEF,
    localparam int DEPTH  = 2 * PIXELS_PER_BUS,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfpl_pkg::est_req_t   req,
    input  lfpl_pkg::est_cfg_t   cfg,
    input  logic [CNT_W-1:0]     count,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [31:0]          rd_data,
    output lfpl_pkg::est_rsp_t   rsp
);

    import lfpl_pkg::*;

    localparam int TERM_W = 18;
    localparam int ACC_W  = (ADDR_W + TERM_W > 24) ? ADDR_W + TERM_W : 24;

    localparam logic [2:0] E_IDLE  = 3'd0;
    localparam logic [2:0] E_RUN   = 3'd1;
    localparam logic [2:0] E_DRAIN = 3'd2;
    localparam logic [2:0] E_DIV   = 3'd3;
    localparam logic [2:0] E_ADD   = 3'd4;

    // floor(x / 255) for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [7:0]        scale_reg, scale_next;
    logic              v0_reg, v1_reg, v2_reg, v3_reg;
    logic [3:0][15:0]  p1_reg, p1_next;
    logic [3:0][7:0]   b2_reg, b2_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [16:0]       quot_reg, quot_next;
    logic              sat_reg, sat_next;
    logic [15:0]       total_reg, total_next;
    logic              done_reg, done_next;

    logic [8:0]        bright_p1;
    logic [9:0]        rgb_sum;
    logic [23:0]       div_in;
    logic [48:0]       prod;
    logic [17:0]       tot_sum;
    logic [16:0]       mb [4];

    // datapath stages
    always_comb
    begin
        bright_p1 = 9'(cfg.bright) + 9'd1;
        for (int c = 0; c < 4; c++)
        begin
            p1_next[c] = 16'(rd_data[8*c +: 8]) * 16'(scale_reg);
            mb[c]      = 17'(div255(p1_reg[c])) * 17'(bright_p1);
            b2_next[c] = mb[c][15:8];
        end
        rgb_sum   = 10'(b2_reg[0]) + 10'(b2_reg[1]) + 10'(b2_reg[2]);
        term_next = TERM_W'(rgb_sum) * TERM_W'(cfg.color_current)
                  + TERM_W'(b2_reg[3]) * TERM_W'(cfg.white_current);
        div_in    = acc_reg[23:0] + 24'd254;
        prod      = 49'(div_in) * 49'(RECIP_255);
        sat_next  = acc_reg > ACC_W'(SUM_SAT);
        quot_next = prod[48:32];
        tot_sum   = 18'(cfg.idle_current) + 18'(quot_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        scale_next = scale_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        done_next  = 1'b0;
        rd_en      = 1'b0;
        if (v3_reg)
        begin
            acc_next = acc_reg + ACC_W'(term_reg);
        end
        unique case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    scale_next = req.scale;
                    state_next = E_RUN;
                end
            end
            E_RUN:
            begin
                rd_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == count)
                begin
                    state_next = E_DRAIN;
                end
            end
            E_DRAIN:
            begin
                if (!v0_reg && !v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = E_DIV;
                end
            end
            E_DIV:
            begin
                state_next = E_ADD;
            end
            E_ADD:
            begin
                total_next = (sat_reg || tot_sum[17:16] != 2'd0) ? 16'hFFFF : tot_sum[15:0];
                done_next  = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    assign rd_addr = idx_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            idx_reg   <= '0;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            v0_reg    <= rd_en;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
        p1_reg    <= p1_next;
        b2_reg    <= b2_next;
        term_reg  <= term_next;
        acc_reg   <= acc_next;
        quot_reg  <= quot_next;
        sat_reg   <= sat_next;
        total_reg <= total_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.total = total_reg;

endmodule

`default_nettype wire

### src/lfpl_checker.sv
// port-level checks of the led frame power limiter and their bind
`default_nettype none

module lfpl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_scale,
    input logic [15:0] demand_current,
    input logic [15:0] drawn_current,
    input logic [15:0] peak_demand,
    input logic [31:0] limited_frame_count
);

    // a held result stays valid and keeps its scale and drawn current
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_scale) && $stable(drawn_current))
        else $error("result changed while stalled");

    // the peak covers this frame's demand
    a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_demand >= demand_current)
        else $error("peak below demand");

    // applied scale never raises the estimate above full scale
    a_drawn_le_demand: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drawn_current <= demand_current)
        else $error("drawn current above demand");

    // a limited frame has been counted
    a_limited_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_scale != 8'hFF |-> limited_frame_count != 32'd0)
        else $error("limited frame not counted");

endmodule

bind led_frame_power_limiter_core lfpl_checker u_lfpl_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_scale           (out_scale),
    .demand_current      (demand_current),
    .drawn_current       (drawn_current),
    .peak_demand         (peak_demand),
    .limited_frame_count (limited_frame_count)
);

`default_nettype wire

### dv/tb.sv
// testbench of the led frame power limiter core: queued pixel driver, frame report checker
`timescale 1ns / 1ps

module tb;

    localparam int PIX_PER_BUS  = lfpl_pkg::PIXELS_PER_BUS_DEF;
    localparam int STORE_DEPTH  = 2 * PIX_PER_BUS;
    localparam int RANDOM_ITEMS = 700;
    localparam int LONG_HOLD    = 4000;      // receiver hold-off, longer than two frame ends
    localparam int CFG_SETTLE   = 20;        // pixel transfers finish well within this
    localparam int END_SETTLE   = 1500;      // about one full frame end of ten passes
    localparam int CYCLE_LIMIT  = 5000000;

    localparam logic [7:0] BRIGHT_FULL = 8'd255;
    localparam logic [lfpl_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 3'd5;
    localparam logic [lfpl_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
        logic       bus_select;
        logic [5:0] pixel_slot;
        logic       end_of_frame;
        logic [7:0] frame_brightness;
        logic       two_buses;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0]  scale;
        logic [15:0] demand;
        logic [15:0] drawn;
        logic [15:0] peak;
        logic [31:0] limited;
    } frame_report_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // pixel channel, payload taken from the item on offer
    logic        in_valid = 1'b0;
    logic        in_ready;
    pixel_item_t offered  = '0;
    logic [7:0]  red, green, blue, white, frame_brightness;
    logic        bus_select, end_of_frame, two_buses;
    logic [5:0]  pixel_slot;

    assign red              = offered.red;
    assign green            = offered.green;
    assign blue             = offered.blue;
    assign white            = offered.white;
    assign bus_select       = offered.bus_select;
    assign pixel_slot       = offered.pixel_slot;
    assign end_of_frame     = offered.end_of_frame;
    assign frame_brightness = offered.frame_brightness;
    assign two_buses        = offered.two_buses;

    // report channel
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_scale;
    logic [15:0] demand_current;
    logic [15:0] drawn_current;
    logic [15:0] peak_demand;
    logic [31:0] limited_frame_count;

    // configuration port
    logic                           cfg_we    = 1'b0;
    logic [lfpl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lfpl_pkg::CFG_W-1:0]     cfg_data  = '0;

    led_frame_power_limiter_core dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .red                 (red),
        .green               (green),
        .blue                (blue),
        .white               (white),
        .bus_select          (bus_select),
        .pixel_slot          (pixel_slot),
        .end_of_frame        (end_of_frame),
        .frame_brightness    (frame_brightness),
        .two_buses           (two_buses),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .out_scale           (out_scale),
        .demand_current      (demand_current),
        .drawn_current       (drawn_current),
        .peak_demand         (peak_demand),
        .limited_frame_count (limited_frame_count),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // shadow of the block: pixel store, applied scale, peak, limited frames, registers
    logic [31:0] store_shadow [STORE_DEPTH];
    logic [7:0]  scale_shadow   = lfpl_pkg::SCALE_FULL;
    logic [15:0] peak_shadow    = '0;
    logic [31:0] limited_shadow = '0;
    logic        limit_on_reg   = lfpl_pkg::LIMIT_ON_RST;
    logic [15:0] budget_reg     = lfpl_pkg::POWER_BUDGET_RST;
    logic [15:0] idle_reg       = lfpl_pkg::IDLE_CURRENT_RST;
    logic [7:0]  color_reg      = lfpl_pkg::COLOR_CURRENT_RST;
    logic [7:0]  white_reg      = lfpl_pkg::WHITE_CURRENT_RST;

    pixel_item_t   pixel_queue[$];
    frame_report_t expected_reports[$];

    // handshakes seen at the last rising edge
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    // pacing knobs, set per phase by the sequence
    int send_idle_max = 0;
    int recv_idle_max = 0;
    int send_wait     = 0;
    int recv_wait     = 0;
    int stall_req     = 0;
    int stall_ack     = 0;
    int hold_left     = 0;

    int err_count        = 0;
    int cycle_count      = 0;
    int items_queued     = 0;
    int pixel_transfers  = 0;
    int reports_checked  = 0;
    int limited_reports  = 0;
    int saturated_frames = 0;
    int settings_applied = 0;

    // strip current at a given scale over the stored pixels, as the block estimates it
    function automatic logic [15:0] strip_current(logic [7:0] bright, logic two,
                                                  logic [7:0] scale);
        int unsigned sum;
        int unsigned total;
        int unsigned v;
        int unsigned ch [4];
        int          npix;
        sum  = 0;
        npix = two ? STORE_DEPTH : PIX_PER_BUS;
        for (int i = 0; i < npix; i++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                v = store_shadow[i][8*c +: 8];
                // power scale first, floor of v*s/255
                if (scale != lfpl_pkg::SCALE_FULL)
                    v = (v * scale) / 255;
                // then brightness, v*(b+1)>>8
                if (bright != BRIGHT_FULL)
                    v = (v * (bright + 1)) >> 8;
                ch[c] = v;
            end
            sum += (ch[0] + ch[1] + ch[2]) * color_reg + ch[3] * white_reg;
        end
        // ceiling division, idle current, saturation at 16 bits
        total = idle_reg + (sum + 254) / 255;
        if (total > 65535)
            return 16'hFFFF;
        return 16'(total);
    endfunction

    // store the pixel of an accepted item; on a frame end work out the report
    function automatic void predict_frame(pixel_item_t it);
        logic [15:0]   demand;
        logic [15:0]   drawn;
        int unsigned   lo, hi, mid, safe, up;
        frame_report_t rep;
        if (it.pixel_slot < PIX_PER_BUS)
            store_shadow[it.bus_select * PIX_PER_BUS + it.pixel_slot] =
                {it.white, it.blue, it.green, it.red};
        if (!it.end_of_frame)
            return;
        demand = strip_current(it.frame_brightness, it.two_buses, lfpl_pkg::SCALE_FULL);
        safe   = lfpl_pkg::SCALE_FULL;
        if (limit_on_reg && demand > budget_reg)
        begin
            // largest scale whose estimate fits the budget
            lo = 0;
            hi = lfpl_pkg::SCALE_FULL;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                if (strip_current(it.frame_brightness, it.two_buses, 8'(mid)) <= budget_reg)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            safe = lo;
        end
        // drop at once, recover by one release step per frame
        if (!limit_on_reg)
            scale_shadow = lfpl_pkg::SCALE_FULL;
        else if (safe < scale_shadow)
            scale_shadow = 8'(safe);
        else if (safe > scale_shadow)
        begin
            up = scale_shadow + lfpl_pkg::RELEASE_STEP;
            scale_shadow = 8'((up < safe) ? up : safe);
        end
        drawn = strip_current(it.frame_brightness, it.two_buses, scale_shadow);
        if (demand > peak_shadow)
            peak_shadow = demand;
        if (limit_on_reg && scale_shadow < lfpl_pkg::SCALE_FULL && limited_shadow != '1)
            limited_shadow++;
        if (scale_shadow < lfpl_pkg::SCALE_FULL)
            limited_reports++;
        if (demand == 16'hFFFF)
            saturated_frames++;
        rep.scale   = scale_shadow;
        rep.demand  = demand;
        rep.drawn   = drawn;
        rep.peak    = peak_shadow;
        rep.limited = limited_shadow;
        expected_reports.push_back(rep);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    function automatic void check_report();
        frame_report_t want;
        if (expected_reports.size() == 0)
        begin
            $display("%0t: frame report with none expected, expected nothing, actual scale %0d",
                     $time, out_scale);
            err_count++;
            return;
        end
        want = expected_reports.pop_front();
        compare_field("out_scale", want.scale, out_scale);
        compare_field("demand_current", want.demand, demand_current);
        compare_field("drawn_current", want.drawn, drawn_current);
        compare_field("peak_demand", want.peak, peak_demand);
        compare_field("limited_frame_count", want.limited, limited_frame_count);
        reports_checked++;
    endfunction

    // monitor: every transfer is seen at the rising edge
    always @(posedge clk)
    begin
        in_taken  <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_frame(offered);
                pixel_transfers++;
            end
            if (out_valid && out_ready)
                check_report();
        end
    end

    // driver: one item on offer at a time, random gap after each transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                send_wait = $urandom_range(0, send_idle_max);
            if (!in_valid || in_taken)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    offered  <= pixel_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random wait per report, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_req != stall_ack)
            begin
                stall_ack = stall_req;
                hold_left = LONG_HOLD;
            end
            if (out_taken)
                recv_wait = $urandom_range(0, recv_idle_max);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0 && out_valid)
            begin
                // the wait runs only while a report is on offer
                recv_wait--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_item(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] w,
                             logic bus, logic [5:0] slot, logic eof, logic [7:0] bright,
                             logic two);
        pixel_item_t it;
        it = '{r, g, b, w, bus, slot, eof, bright, two};
        pixel_queue.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] chan_value();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_item_t rand_item(logic eof);
        pixel_item_t it;
        it.red              = chan_value();
        it.green            = chan_value();
        it.blue             = chan_value();
        it.white            = chan_value();
        it.bus_select       = 1'($urandom_range(0, 1));
        it.pixel_slot       = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 1) * 63)
                                                          : 6'($urandom_range(0, 63));
        it.end_of_frame     = eof;
        it.frame_brightness = ($urandom_range(0, 2) == 0) ? BRIGHT_FULL : chan_value();
        it.two_buses        = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // wait until the block has drained: nothing on offer, no report outstanding
    task automatic settle_block();
        while (pixel_queue.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [lfpl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        logic known;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        known = 1'b1;
        case (idx)
            lfpl_pkg::CFG_LIMIT_ON:      limit_on_reg = data[0];
            lfpl_pkg::CFG_POWER_BUDGET:  budget_reg   = data;
            lfpl_pkg::CFG_IDLE_CURRENT:  idle_reg     = data;
            lfpl_pkg::CFG_COLOR_CURRENT: color_reg    = data[7:0];
            lfpl_pkg::CFG_WHITE_CURRENT: white_reg    = data[7:0];
            default:                     known        = 1'b0;
        endcase
        // any real write with the limiter off forces full scale
        if (known && !limit_on_reg)
            scale_shadow = lfpl_pkg::SCALE_FULL;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick16(int unsigned typical_hi);
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, typical_hi));
        endcase
    endfunction

    function automatic logic [7:0] pick8();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom);
            default: return 8'($urandom_range(5, 40));
        endcase
    endfunction

    // one full register setting, with random upper bits on the narrow registers
    task automatic program_setting();
        logic [15:0] data;
        data    = 16'($urandom);
        data[0] = ($urandom_range(0, 4) != 0);
        write_reg(lfpl_pkg::CFG_LIMIT_ON, data);
        write_reg(lfpl_pkg::CFG_POWER_BUDGET, pick16(4000));
        write_reg(lfpl_pkg::CFG_IDLE_CURRENT, pick16(120));
        write_reg(lfpl_pkg::CFG_COLOR_CURRENT, {8'($urandom), pick8()});
        write_reg(lfpl_pkg::CFG_WHITE_CURRENT, {8'($urandom), pick8()});
        if ($urandom_range(0, 3) == 0)
            write_reg(lfpl_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_LO,
                                                          CFG_IDX_UNUSED_HI)),
                      16'($urandom));
        settings_applied++;
    endtask

    // a short frame of random pixels closed by a frame end, or a lone noise item
    task automatic random_frame();
        int npix;
        if ($urandom_range(0, 7) == 0)
        begin
            pixel_queue.push_back(rand_item(1'($urandom_range(0, 1))));
            items_queued++;
            return;
        end
        npix = $urandom_range(0, 12);
        repeat (npix)
        begin
            pixel_queue.push_back(rand_item(1'b0));
            items_queued++;
        end
        pixel_queue.push_back(rand_item(1'b1));
        items_queued++;
    endtask

    // stimulus sequence
    initial
    begin
        int phase;
        int directed_items;
        for (int i = 0; i < STORE_DEPTH; i++)
            store_shadow[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, reset settings first
        // frame end over the cleared store: demand is the idle current alone
        push_item(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 6'd0, 1'b1, BRIGHT_FULL, 1'b1);
        // slot extremes on both buses
        push_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 6'd0, 1'b0, 8'd0, 1'b0);
        push_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 6'd63, 1'b0, 8'd0, 1'b0);
        push_item(8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 6'd63, 1'b0, 8'd0, 1'b0);
        push_item(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 6'd0, 1'b1, BRIGHT_FULL, 1'b1);
        // bus 1 left out of the count
        push_item(8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 6'd1, 1'b1, BRIGHT_FULL, 1'b0);
        settle_block();

        // tight budget: scale drops at once, then recovers step by step
        write_reg(lfpl_pkg::CFG_POWER_BUDGET, 16'd100);
        push_item(8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 6'd2, 1'b1, BRIGHT_FULL, 1'b1);
        push_item(8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 6'd2, 1'b1, BRIGHT_FULL, 1'b1);
        repeat (3)
            push_item(8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 6'd2, 1'b1, 8'd0, 1'b1);
        push_item(8'd10, 8'd20, 8'd30, 8'd40, 1'b0, 6'd3, 1'b1, 8'd128, 1'b0);
        settle_block();

        // limiter off forces full scale and counts nothing
        write_reg(lfpl_pkg::CFG_LIMIT_ON, 16'hFFFE);
        push_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 6'd5, 1'b1, BRIGHT_FULL, 1'b1);
        settle_block();

        // saturated demand: no scale fits, search ends at zero
        write_reg(lfpl_pkg::CFG_LIMIT_ON, 16'd1);
        write_reg(lfpl_pkg::CFG_IDLE_CURRENT, 16'hFFFF);
        push_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 6'd6, 1'b1, BRIGHT_FULL, 1'b1);
        settle_block();

        // heaviest channel weights, zero budget and idle current
        write_reg(lfpl_pkg::CFG_IDLE_CURRENT, 16'd0);
        write_reg(lfpl_pkg::CFG_POWER_BUDGET, 16'd0);
        write_reg(lfpl_pkg::CFG_COLOR_CURRENT, 16'hFFFF);
        write_reg(lfpl_pkg::CFG_WHITE_CURRENT, 16'h00FF);
        push_item(8'd255, 8'd254, 8'd1, 8'd128, 1'b0, 6'd7, 1'b1, BRIGHT_FULL, 1'b1);
        push_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 6'd7, 1'b1, 8'd254, 1'b1);
        settle_block();

        // writes to unused indexes change nothing
        write_reg(CFG_IDX_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_IDX_UNUSED_HI, 16'h0000);
        push_item(8'd1, 8'd2, 8'd3, 8'd4, 1'b0, 6'd8, 1'b1, 8'd200, 1'b0);
        directed_items = items_queued;

        // random phases, one register setting each
        phase = 0;
        while (items_queued < directed_items + RANDOM_ITEMS)
        begin
            settle_block();
            program_setting();
            send_idle_max = (phase % 3 == 0) ? 0 : 6;
            recv_idle_max = (phase % 4 == 1) ? 0 : 6;
            if (phase == 2)
            begin
                // fill the whole store once with random pixels at full brightness
                for (int s = 0; s < STORE_DEPTH; s++)
                    push_item(chan_value(), chan_value(), chan_value(), chan_value(),
                              1'(s / PIX_PER_BUS), 6'(s % PIX_PER_BUS),
                              (s == STORE_DEPTH - 1), BRIGHT_FULL, 1'b1);
            end
            else if (phase == 4 || phase == 9)
            begin
                // receiver holds off while frames keep coming: the block backs up
                send_idle_max = 0;
                stall_req++;
                repeat (5)
                begin
                    repeat (2)
                    begin
                        pixel_queue.push_back(rand_item(1'b0));
                        items_queued++;
                    end
                    pixel_queue.push_back(rand_item(1'b1));
                    items_queued++;
                end
            end
            else
                repeat ($urandom_range(2, 6)) random_frame();
            phase++;
        end

        // drain and watch for stray reports
        settle_block();
        repeat (END_SETTLE) @(posedge clk);

        $display("run covered %0d pixel transfers and %0d frame reports over %0d settings",
                 pixel_transfers, reports_checked, settings_applied);
        $display("%0d reports came at reduced scale, %0d with saturated demand",
                 limited_reports, saturated_frames);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
src/lfpl_pkg.sv
src/lfpl_store.sv
src/lfpl_est_unit.sv
src/led_frame_power_limiter_core.sv
src/lfpl_checker.sv
dv/tb.sv
